/* design/ps2m_pkg.sv */
// ----------------------------------------------------------------------------
// ps2m_pkg
// Shared types, widths and helpers for the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2m_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 13;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;

    localparam logic [CFG_BITS-1:0] RESET_WIDTH  = 13'd800;
    localparam logic [CFG_BITS-1:0] RESET_HEIGHT = 13'd600;

    localparam logic [COORD_BITS-1:0] RESET_X = COORD_BITS'((400 > COORD_MAX) ? COORD_MAX : 400);
    localparam logic [COORD_BITS-1:0] RESET_Y = COORD_BITS'((300 > COORD_MAX) ? COORD_MAX : 300);

    // flag byte bits
    localparam int FLAG_SYNC  = 3;
    localparam int FLAG_XSIGN = 4;
    localparam int FLAG_YSIGN = 5;
    localparam int FLAG_XOVF  = 6;
    localparam int FLAG_YOVF  = 7;

    // register indexes (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       from_aux;
    } t_in_beat;

    typedef struct packed {
        logic [11:0] cursor_x;
        logic [11:0] cursor_y;
        logic [2:0]  button_bits;
        logic        moved;
    } t_out_beat;

    typedef struct packed {
        logic sign;
        logic skip;
        logic subtract;
    } t_axis_ctl;

    function automatic logic [COORD_BITS-1:0] axis_limit(input logic [CFG_BITS-1:0] size);
        int v;
        v = (size == '0) ? 0 : int'(size) - 1;
        if (v > COORD_MAX) begin
            v = COORD_MAX;
        end
        return COORD_BITS'(v);
    endfunction

endpackage

/* design/ps2m_axis.sv */
// ----------------------------------------------------------------------------
// ps2m_axis
// One cursor axis: adds or subtracts a 9-bit signed delta (or holds on skip) and clamps to [0, limit].
// ----------------------------------------------------------------------------
module ps2m_axis (
    input  logic [ps2m_pkg::COORD_BITS-1:0] i_pos,
    input  logic [7:0]                      i_delta,
    input  ps2m_pkg::t_axis_ctl             i_ctl,
    input  logic [ps2m_pkg::COORD_BITS-1:0] i_limit,
    output logic [ps2m_pkg::COORD_BITS-1:0] o_pos
);

    localparam int W = ps2m_pkg::COORD_BITS;

    logic signed [W+1:0] s_pos;
    logic signed [W+1:0] s_delta;
    logic signed [W+1:0] s_sum;
    logic signed [W+1:0] s_lim;

    assign s_pos   = signed'({2'b00, i_pos});
    assign s_delta = signed'({{(W-6){i_ctl.sign}}, i_delta});
    assign s_lim   = signed'({2'b00, i_limit});

    always_comb begin
        if (i_ctl.skip) begin
            s_sum = s_pos;
        end else if (i_ctl.subtract) begin
            s_sum = s_pos - s_delta;
        end else begin
            s_sum = s_pos + s_delta;
        end
        if (s_sum < 0) begin
            o_pos = '0;
        end else if (s_sum > s_lim) begin
            o_pos = i_limit;
        end else begin
            o_pos = s_sum[W-1:0];
        end
    end

endmodule

/* design/ps2_mouse_packet_cursor_tracker.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Decodes three-byte PS/2 mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_in_beat) carries controller bytes
//   tagged with from_aux; untagged bytes are dropped. Output channel
//   (o_valid / i_stall / o_out_beat) carries one beat per completed packet:
//   position, buttons and a moved flag.
//   Path: a packet's third byte, once accepted, passes the input register,
//   then the result register, before it shows up as an output beat.
//   Throughput: one byte per cycle while the output is not stalled; the state
//   update is a single add or subtract and clamp per axis between the two registers.
//   A stalled output beat holds; the input register then fills and o_stall
//   is raised until the receiver takes the beat.
//   Reset: phase waits for a flag byte, cursor at (400, 300), buttons clear,
//   screen 800 x 600. Screen size is set over the APB port (width at 0x0,
//   height at 0x4); the user must write it only while the block is idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  ps2m_pkg::t_in_beat               i_in_beat,
    output logic                             o_valid,
    input  logic                             i_stall,
    output ps2m_pkg::t_out_beat              o_out_beat,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ps2m_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [ps2m_pkg::DATA_BITS-1:0]   pwdata,
    output logic [ps2m_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready
);

    localparam int W = ps2m_pkg::COORD_BITS;

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_X    = 2'd1;
    localparam logic [1:0] PH_Y    = 2'd2;

    logic [ps2m_pkg::CFG_BITS-1:0] r_width;
    logic [ps2m_pkg::CFG_BITS-1:0] r_height;

    logic                r_in_valid;
    ps2m_pkg::t_in_beat  r_in;
    logic                r_out_valid;
    ps2m_pkg::t_out_beat r_out;

    logic [1:0]   r_phase;
    logic [7:0]   r_flag;
    logic [7:0]   r_xbyte;
    logic [W-1:0] r_pos_x;
    logic [W-1:0] r_pos_y;
    logic [2:0]   r_buttons;

    logic [1:0]   n_phase;
    logic         advance;
    logic         take;
    logic         fire;
    logic [W-1:0] lim_x;
    logic [W-1:0] lim_y;
    logic [W-1:0] n_pos_x;
    logic [W-1:0] n_pos_y;
    ps2m_pkg::t_axis_ctl ctl_x;
    ps2m_pkg::t_axis_ctl ctl_y;
    ps2m_pkg::t_out_beat n_out;
    logic         cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ps2m_pkg::RESET_WIDTH;
            r_height <= ps2m_pkg::RESET_HEIGHT;
        end else if (cfg_wr) begin
            if (paddr[2] == ps2m_pkg::REG_WIDTH) begin
                r_width <= pwdata[ps2m_pkg::CFG_BITS-1:0];
            end else begin
                r_height <= pwdata[ps2m_pkg::CFG_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ps2m_pkg::REG_WIDTH) begin
            prdata = {{(ps2m_pkg::DATA_BITS-ps2m_pkg::CFG_BITS){1'b0}}, r_width};
        end else begin
            prdata = {{(ps2m_pkg::DATA_BITS-ps2m_pkg::CFG_BITS){1'b0}}, r_height};
        end
    end

    // pipeline control
    assign advance = !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && !advance;
    assign take    = r_in_valid && r_in.from_aux && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in <= i_in_beat;
        end
    end

    // packet decode
    always_comb begin
        fire = 1'b0;
        case (r_phase)
            PH_X: begin
                n_phase = PH_Y;
            end
            PH_Y: begin
                n_phase = PH_FLAG;
                fire    = 1'b1;
            end
            default: begin
                n_phase = r_in.rx_byte[ps2m_pkg::FLAG_SYNC] ? PH_X : PH_FLAG;
            end
        endcase
    end

    assign lim_x = ps2m_pkg::axis_limit(r_width);
    assign lim_y = ps2m_pkg::axis_limit(r_height);

    assign ctl_x = '{sign:     r_flag[ps2m_pkg::FLAG_XSIGN],
                     skip:     r_flag[ps2m_pkg::FLAG_XOVF],
                     subtract: 1'b0};
    assign ctl_y = '{sign:     r_flag[ps2m_pkg::FLAG_YSIGN],
                     skip:     r_flag[ps2m_pkg::FLAG_YOVF],
                     subtract: 1'b1};

    ps2m_axis u_axis_x (
        .i_pos   (r_pos_x),
        .i_delta (r_xbyte),
        .i_ctl   (ctl_x),
        .i_limit (lim_x),
        .o_pos   (n_pos_x)
    );

    ps2m_axis u_axis_y (
        .i_pos   (r_pos_y),
        .i_delta (r_in.rx_byte),
        .i_ctl   (ctl_y),
        .i_limit (lim_y),
        .o_pos   (n_pos_y)
    );

    always_comb begin
        n_out.cursor_x    = 12'(n_pos_x);
        n_out.cursor_y    = 12'(n_pos_y);
        n_out.button_bits = r_flag[2:0];
        n_out.moved       = (r_xbyte != 8'd0) || (r_in.rx_byte != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FLAG;
            r_flag    <= '0;
            r_xbyte   <= '0;
            r_pos_x   <= ps2m_pkg::RESET_X;
            r_pos_y   <= ps2m_pkg::RESET_Y;
            r_buttons <= '0;
        end else if (take) begin
            r_phase <= n_phase;
            if (fire) begin
                r_pos_x   <= n_pos_x;
                r_pos_y   <= n_pos_y;
                r_buttons <= r_flag[2:0];
            end else if (r_phase == PH_X) begin
                r_xbyte <= r_in.rx_byte;
            end else begin
                r_flag <= r_in.rx_byte;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= take && fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_beat = r_out;

    // checks
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall && r_in_valid))
        else $error("input stalled without a blocked output beat");

    a_beat_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_in_valid && r_in.from_aux && r_phase == PH_Y))
        else $error("output beat without a third packet byte");

    a_buttons_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_beat.button_bits == r_buttons))
        else $error("output buttons differ from held buttons");

endmodule

/* dv/ps2_mouse_packet_cursor_tracker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_tb
// Self-checking bench for the PS/2 mouse packet decoder and cursor tracker.
// Controller bytes go in one beat at a time. An in-bench tracker mirrors the
// packet framing, the delta decode and the screen clamp, and queues the
// cursor beat that each completed packet should produce. The output monitor
// compares every beat against the oldest queued one. Screen size is changed
// over APB between phases, with both sides idling in random bursts until the
// final back-to-back phase.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_tb;

    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 5000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    ps2m_pkg::t_in_beat             i_in_beat;
    logic                           o_valid;
    logic                           i_stall;
    ps2m_pkg::t_out_beat            o_out_beat;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ps2m_pkg::ADDR_BITS-1:0] paddr;
    logic [ps2m_pkg::DATA_BITS-1:0] pwdata;
    logic [ps2m_pkg::DATA_BITS-1:0] prdata;
    logic                           pready;

    // tracker state
    logic [1:0]                    pkt_phase;
    logic [7:0]                    pkt_flags;
    logic [7:0]                    pkt_xbyte;
    int                            trk_x;
    int                            trk_y;
    logic [ps2m_pkg::CFG_BITS-1:0] scr_width;
    logic [ps2m_pkg::CFG_BITS-1:0] scr_height;

    ps2m_pkg::t_out_beat expected_cursor_q[$];
    int                  mismatch_count;
    bit                  pace;
    int                  stall_run;

    ps2_mouse_packet_cursor_tracker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_beat  (i_in_beat),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_beat (o_out_beat),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        mismatch_count++;
        $display("%0t: mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    endtask

    function automatic int bound_of(input logic [ps2m_pkg::CFG_BITS-1:0] size);
        int lim;
        lim = (size == 0) ? 0 : int'(size) - 1;
        return (lim > ps2m_pkg::COORD_MAX) ? ps2m_pkg::COORD_MAX : lim;
    endfunction

    // Advance the tracker by one accepted byte; returns 1 when a packet completes.
    function automatic bit track_mouse_byte(input ps2m_pkg::t_in_beat beat,
                                            output ps2m_pkg::t_out_beat res);
        int dx;
        int dy;
        res = '0;
        if (!beat.from_aux) begin
            return 1'b0;
        end
        if (pkt_phase == 2'd1) begin
            pkt_xbyte = beat.rx_byte;
            pkt_phase = 2'd2;
            return 1'b0;
        end
        if (pkt_phase != 2'd2) begin
            pkt_flags = beat.rx_byte;
            pkt_phase = beat.rx_byte[ps2m_pkg::FLAG_SYNC] ? 2'd1 : 2'd0;
            return 1'b0;
        end
        pkt_phase = 2'd0;
        dx = int'(pkt_xbyte) - (pkt_flags[ps2m_pkg::FLAG_XSIGN] ? 256 : 0);
        dy = int'(beat.rx_byte) - (pkt_flags[ps2m_pkg::FLAG_YSIGN] ? 256 : 0);
        if (!pkt_flags[ps2m_pkg::FLAG_XOVF]) begin
            trk_x += dx;
        end
        if (!pkt_flags[ps2m_pkg::FLAG_YOVF]) begin
            trk_y -= dy;
        end
        if (trk_x < 0) trk_x = 0;
        if (trk_x > bound_of(scr_width)) trk_x = bound_of(scr_width);
        if (trk_y < 0) trk_y = 0;
        if (trk_y > bound_of(scr_height)) trk_y = bound_of(scr_height);
        res.cursor_x    = trk_x[11:0];
        res.cursor_y    = trk_y[11:0];
        res.button_bits = pkt_flags[2:0];
        res.moved       = (pkt_xbyte != 8'h00) || (beat.rx_byte != 8'h00);
        return 1'b1;
    endfunction

    task automatic send_beat(input logic [7:0] data, input logic aux);
        ps2m_pkg::t_in_beat  beat;
        ps2m_pkg::t_out_beat res;
        int                  gap;
        beat.rx_byte  = data;
        beat.from_aux = aux;
        if (pace && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_in_beat <= beat;
        do @(posedge i_clk); while (o_stall);
        if (track_mouse_byte(beat, res)) begin
            expected_cursor_q.push_back(res);
        end
    endtask

    task automatic send_packet(input logic [7:0] flags, input logic [7:0] xb,
                               input logic [7:0] yb);
        send_beat(flags, 1'b1);
        send_beat(xb, 1'b1);
        send_beat(yb, 1'b1);
    endtask

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return ($urandom_range(0, 1) == 0) ? 8'hFF : 8'h80;
            2: return 8'h7F;
            3: return 8'($urandom_range(0, 7));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_packet();
        logic [7:0] flags;
        flags = 8'($urandom);
        flags[ps2m_pkg::FLAG_SYNC] = 1'b1;
        flags[ps2m_pkg::FLAG_XOVF] = ($urandom_range(0, 7) == 0);
        flags[ps2m_pkg::FLAG_YOVF] = ($urandom_range(0, 7) == 0);
        send_packet(flags, pick_delta(), pick_delta());
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Wait until every queued cursor beat is out (or the drain limit is reached), then let the pipe settle.
    task automatic wait_quiet();
        int waited;
        waited = 0;
        idle_input();
        while (expected_cursor_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic reg_sel,
                             input logic [ps2m_pkg::DATA_BITS-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == ps2m_pkg::REG_WIDTH) begin
            scr_width = data[ps2m_pkg::CFG_BITS-1:0];
        end else begin
            scr_height = data[ps2m_pkg::CFG_BITS-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_screen(input int w, input int h);
        logic [ps2m_pkg::DATA_BITS-1:0] wd;
        logic [ps2m_pkg::DATA_BITS-1:0] hd;
        wd = $urandom;
        hd = $urandom;
        wd[ps2m_pkg::CFG_BITS-1:0] = ps2m_pkg::CFG_BITS'(w);
        hd[ps2m_pkg::CFG_BITS-1:0] = ps2m_pkg::CFG_BITS'(h);
        wait_quiet();
        apb_write(ps2m_pkg::REG_WIDTH, wd);
        apb_write(ps2m_pkg::REG_HEIGHT, hd);
    endtask

    task automatic test_directed_packets();
        send_beat(8'hFF, 1'b0);
        send_packet(8'h08, 8'h00, 8'h00);
        send_beat(8'h00, 1'b1);              // resync: no sync bit
        send_beat(8'h0F, 1'b1);
        send_beat(8'hA5, 1'b0);              // foreign byte mid-packet
        send_beat(8'h7F, 1'b1);
        send_beat(8'h80, 1'b1);
        send_packet(8'h3F, 8'h00, 8'h00);    // both signs, -256 each way
        send_packet(8'h48, 8'hFF, 8'h01);    // x overflow
        send_packet(8'h88, 8'h01, 8'hFF);    // y overflow
        send_packet(8'hF8, 8'h80, 8'h80);    // both overflow
        send_packet(8'h08, 8'hFF, 8'hFF);
    endtask

    task automatic test_screen_sizes();
        int n;
        set_screen(8191, 4097);
        for (n = 0; n < 18; n++) begin
            send_packet(8'h28, 8'hFF, 8'h00);    // drive to the far corner
        end
        repeat (10) send_random_packet();
        set_screen(4096, 4096);
        repeat (5) send_random_packet();
        for (n = 0; n < 18; n++) begin
            send_packet(8'h18, 8'h00, 8'h7F);    // back toward the origin
        end
        set_screen(1, 1);
        repeat (10) send_random_packet();
        set_screen(0, 0);
        repeat (10) send_random_packet();
        set_screen(2, 3);
        repeat (12) send_random_packet();
        set_screen($urandom_range(1, 4096), $urandom_range(1, 4096));
        repeat (15) send_random_packet();
        set_screen(ps2m_pkg::RESET_WIDTH, ps2m_pkg::RESET_HEIGHT);
    endtask

    task automatic test_random_traffic(input int beats);
        int sent;
        sent = 0;
        while (sent < beats) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    send_beat(8'($urandom), 1'b0);
                end
                2: begin
                    send_beat(8'($urandom) & 8'hF7, 1'b1);
                    sent++;
                end
                3: begin
                    send_beat(8'($urandom) | 8'h08, 1'b1);   // truncated packet
                    send_beat(8'($urandom), 1'b1);
                    sent += 2;
                end
                default: begin
                    send_random_packet();
                    sent += 3;
                end
            endcase
        end
    endtask

    // output monitor
    always @(posedge i_clk) begin
        ps2m_pkg::t_out_beat exp_b;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cursor_q.size() == 0) begin
                report_mismatch("unexpected beat, cursor_x", -1, o_out_beat.cursor_x);
            end else begin
                exp_b = expected_cursor_q.pop_front();
                if (o_out_beat.cursor_x !== exp_b.cursor_x)
                    report_mismatch("cursor_x", exp_b.cursor_x, o_out_beat.cursor_x);
                if (o_out_beat.cursor_y !== exp_b.cursor_y)
                    report_mismatch("cursor_y", exp_b.cursor_y, o_out_beat.cursor_y);
                if (o_out_beat.button_bits !== exp_b.button_bits)
                    report_mismatch("button_bits", exp_b.button_bits, o_out_beat.button_bits);
                if (o_out_beat.moved !== exp_b.moved)
                    report_mismatch("moved", exp_b.moved, o_out_beat.moved);
            end
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (!pace) begin
            i_stall   <= 1'b0;
            stall_run = 0;
        end else if (stall_run == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                i_stall   <= 1'b1;
                stall_run = $urandom_range(0, 16);
            end else begin
                i_stall   <= 1'b0;
                stall_run = $urandom_range(0, 40);
            end
        end else begin
            stall_run--;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_in_beat      = '0;
        i_stall        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pace           = 1'b1;
        stall_run      = 0;
        mismatch_count = 0;
        pkt_phase      = 2'd0;
        pkt_flags      = 8'h00;
        pkt_xbyte      = 8'h00;
        trk_x          = int'(ps2m_pkg::RESET_X);
        trk_y          = int'(ps2m_pkg::RESET_Y);
        scr_width      = ps2m_pkg::RESET_WIDTH;
        scr_height     = ps2m_pkg::RESET_HEIGHT;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_packets();
        test_screen_sizes();
        test_random_traffic(500);
        wait_quiet();
        pace = 1'b0;
        test_random_traffic(150);
        wait_quiet();

        if (expected_cursor_q.size() != 0) begin
            report_mismatch("beats never delivered", 0, expected_cursor_q.size());
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* ps2_mouse_packet_cursor_tracker.f */
design/ps2m_pkg.sv
design/ps2m_axis.sv
design/ps2_mouse_packet_cursor_tracker.sv
dv/ps2_mouse_packet_cursor_tracker_tb.sv
